@@ rtl/sl_pkg.sv @@
// Shared types, constants and constant tables for the sRGB luma grayscale block.
// Standalone package; every rtl module refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package sl_pkg;

  // Linear-light precision (unsigned Q0.LINEAR_BITS) and encode index resolution.
  localparam int LINEAR_BITS       = 16;
  localparam int ENCODE_INDEX_BITS = 12;

  localparam int CODE_W = 8;
  localparam int NUM_CODES = 1 << CODE_W;
  localparam int WEIGHT_W = 16;
  localparam int PROD_W = LINEAR_BITS + WEIGHT_W;
  localparam int SUM_W = PROD_W + 2;

  localparam logic [WEIGHT_W-1:0] W_RED   = 16'd13933;
  localparam logic [WEIGHT_W-1:0] W_GREEN = 16'd46871;
  localparam logic [WEIGHT_W-1:0] W_BLUE  = 16'd4732;
  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << (WEIGHT_W - 1));

  localparam longint unsigned LIN_MAX = (64'd1 << LINEAR_BITS) - 64'd1;

  // Low bits of Y that the encode index drops; Y is compared with those bits cleared.
  localparam int ENC_DROP = (LINEAR_BITS > ENCODE_INDEX_BITS) ?
                            (LINEAR_BITS - ENCODE_INDEX_BITS) : 0;
  localparam logic [LINEAR_BITS-1:0] REP_MASK = ~(LINEAR_BITS'((1 << ENC_DROP) - 1));

  // Wide enough for the exact fifth-power / twelfth-power comparisons below.
  localparam int BIG_W = 320;

  typedef logic [NUM_CODES-1:0][LINEAR_BITS-1:0] dec_tab_t;

  // One item in the encode search: the masked luminance and the code found so far.
  typedef struct packed {
    logic [LINEAR_BITS-1:0] rep;
    logic [CODE_W-1:0]      code;
  } search_t;

  // Exactly rounded linear value of code c. On the power segment a value L is
  // kept when ((2L-1)/(2*LIN_MAX))^5 <= ((200c+2805)/53805)^12.
  function automatic logic [LINEAR_BITS-1:0] dec_entry(input int unsigned c);
    logic [BIG_W-1:0]  rhs;
    logic [BIG_W-1:0]  lhs;
    logic [BIG_W-1:0]  base;
    logic [BIG_W-1:0]  m;
    logic [63:0]       lin;
    longint unsigned   lo;
    longint unsigned   hi;
    longint unsigned   mid;
    if (64'(c) * 64'd100000 <= 64'd1031475) begin
      lin = (LIN_MAX * 64'(c) * 64'd200 + 64'd329460) / 64'd658920;
      return LINEAR_BITS'(lin);
    end
    base = BIG_W'(64'd200 * 64'(c) + 64'd2805);
    rhs = base;
    for (int i = 0; i < 11; i++) rhs = rhs * base;
    for (int i = 0; i < 5; i++) rhs = rhs * BIG_W'(64'd2 * LIN_MAX);
    lo = 0;
    hi = LIN_MAX;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 64'd1) >> 1);
      m = BIG_W'(64'd2 * mid - 64'd1);
      lhs = m;
      for (int i = 0; i < 4; i++) lhs = lhs * m;
      for (int i = 0; i < 12; i++) lhs = lhs * BIG_W'(64'd53805);
      if (lhs <= rhs) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    return LINEAR_BITS'(lo);
  endfunction

  function automatic dec_tab_t build_dec_tab();
    dec_tab_t t;
    for (int c = 0; c < NUM_CODES; c++) t[c] = dec_entry(c);
    return t;
  endfunction

  // sRGB code to linear light, round((2^LINEAR_BITS - 1) * lin).
  localparam dec_tab_t DEC_TAB = build_dec_tab();

endpackage

`default_nettype wire

@@ rtl/sl_luma.sv @@
// Decode and luminance front end: three register stages that turn an sRGB
// pixel into masked linear luminance. Depends on sl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sl_luma (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     valid_in,
  input  wire logic [sl_pkg::CODE_W-1:0] red,
  input  wire logic [sl_pkg::CODE_W-1:0] green,
  input  wire logic [sl_pkg::CODE_W-1:0] blue,
  output logic                          valid_out,
  output sl_pkg::search_t               item_out
);

  logic                             valid1;
  logic                             valid2;
  logic [sl_pkg::LINEAR_BITS-1:0]   lin_r;
  logic [sl_pkg::LINEAR_BITS-1:0]   lin_g;
  logic [sl_pkg::LINEAR_BITS-1:0]   lin_b;
  logic [sl_pkg::PROD_W-1:0]        prod_r;
  logic [sl_pkg::PROD_W-1:0]        prod_g;
  logic [sl_pkg::PROD_W-1:0]        prod_b;
  logic [sl_pkg::SUM_W-1:0]         sum;
  logic [sl_pkg::LINEAR_BITS-1:0]   luma;

  // The weights add up to one in Q0.16, so the rounded luminance fits LINEAR_BITS.
  assign sum = sl_pkg::SUM_W'(prod_r) + sl_pkg::SUM_W'(prod_g)
             + sl_pkg::SUM_W'(prod_b) + sl_pkg::ROUND_HALF;
  assign luma = sum[sl_pkg::WEIGHT_W +: sl_pkg::LINEAR_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1    <= 1'b0;
      valid2    <= 1'b0;
      valid_out <= 1'b0;
    end else begin
      valid1    <= valid_in;
      valid2    <= valid1;
      valid_out <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    lin_r <= sl_pkg::DEC_TAB[red];
    lin_g <= sl_pkg::DEC_TAB[green];
    lin_b <= sl_pkg::DEC_TAB[blue];
    prod_r <= sl_pkg::PROD_W'(lin_r) * sl_pkg::PROD_W'(sl_pkg::W_RED);
    prod_g <= sl_pkg::PROD_W'(lin_g) * sl_pkg::PROD_W'(sl_pkg::W_GREEN);
    prod_b <= sl_pkg::PROD_W'(lin_b) * sl_pkg::PROD_W'(sl_pkg::W_BLUE);
    item_out.rep  <= luma & sl_pkg::REP_MASK;
    item_out.code <= '0;
  end

endmodule

`default_nettype wire

@@ rtl/sl_search_step.sv @@
// One registered step of the binary search that re-encodes luminance: decides
// one bit of the gray code against the constant decode table. Depends on sl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sl_search_step #(
  parameter int STEP_BIT = 0
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             valid_in,
  input  wire sl_pkg::search_t  item_in,
  output logic                  valid_out,
  output sl_pkg::search_t       item_out
);

  logic [sl_pkg::CODE_W-1:0] trial;
  logic                      take;

  // The decode table rises with the code, so the largest code whose linear
  // value does not exceed the luminance is found one bit at a time.
  assign trial = item_in.code | sl_pkg::CODE_W'(1 << STEP_BIT);
  assign take  = sl_pkg::DEC_TAB[trial] <= item_in.rep;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    item_out.rep  <= item_in.rep;
    item_out.code <= take ? trial : item_in.code;
  end

endmodule

`default_nettype wire

@@ rtl/srgb_luma_grayscale.sv @@
// Top level of the sRGB to gray converter: luminance front end followed by an
// eight-stage encode search. Depends on sl_pkg, sl_luma and sl_search_step.
//
// Usage: drive red, green and blue and raise start for one cycle per pixel.
// A transfer happens at every rising edge where start is high and busy is low;
// busy is always low, so a new pixel may be presented on every clock.
// Each pixel yields one gray code on gray_out, marked by done for exactly one
// cycle. Throughput is one pixel per cycle; each pixel passes through three
// front-end stages (table decode, weight multiply, sum and round) and then one
// stage per bit of the encode search, and done and gray_out come straight from
// the registers of the last search step.
// Results leave in the order pixels entered. The receiver cannot stall, so
// done is not held and every result must be taken in its cycle.
// A synchronous reset clears all valid bits, so no done pulse follows reset
// until new pixels are transferred. All tables are constants; no fill is needed.
`timescale 1ns / 1ps
`default_nettype none

module srgb_luma_grayscale (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [sl_pkg::CODE_W-1:0] red_in,
  input  wire logic [sl_pkg::CODE_W-1:0] green_in,
  input  wire logic [sl_pkg::CODE_W-1:0] blue_in,
  output logic                           done,
  output logic [sl_pkg::CODE_W-1:0]      gray_out
);

  logic            vld [sl_pkg::CODE_W+1];
  sl_pkg::search_t stg [sl_pkg::CODE_W+1];

  assign busy = 1'b0;

  sl_luma u_luma (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (start),
    .red       (red_in),
    .green     (green_in),
    .blue      (blue_in),
    .valid_out (vld[0]),
    .item_out  (stg[0])
  );

  for (genvar k = 0; k < sl_pkg::CODE_W; k++) begin : g_search
    sl_search_step #(
      .STEP_BIT (sl_pkg::CODE_W - 1 - k)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (vld[k]),
      .item_in   (stg[k]),
      .valid_out (vld[k+1]),
      .item_out  (stg[k+1])
    );
  end

  assign done     = vld[sl_pkg::CODE_W];
  assign gray_out = stg[sl_pkg::CODE_W].code;

endmodule

`default_nettype wire

@@ dv/srgb_luma_grayscale_test.sv @@
// Self-checking testbench for srgb_luma_grayscale: corner pixels, a random pixel stream
// with random gaps and one full drain, and a gapless burst, all checked against a local
// predictor. Depends on sl_pkg for port widths and precision parameters.
`timescale 1ns / 1ps

module srgb_luma_grayscale_test;

  localparam int CW = sl_pkg::CODE_W;
  localparam int LB = sl_pkg::LINEAR_BITS;
  localparam int EIB = sl_pkg::ENCODE_INDEX_BITS;
  localparam int DROP_BITS = (LB > EIB) ? (LB - EIB) : 0;
  localparam longint unsigned LEVEL_MAX = (64'd1 << LB) - 64'd1;
  localparam int unsigned LUMA_R = 13933;
  localparam int unsigned LUMA_G = 46871;
  localparam int unsigned LUMA_B = 4732;
  localparam int RANDOM_PIXELS = 800;
  localparam int CYCLE_LIMIT = 300000;
  localparam int MAX_PRINTED = 40;

  typedef struct {
    logic [CW-1:0] red;
    logic [CW-1:0] green;
    logic [CW-1:0] blue;
    logic [CW-1:0] gray;
  } gray_job_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [CW-1:0] red_in = '0;
  logic [CW-1:0] green_in = '0;
  logic [CW-1:0] blue_in = '0;
  logic busy;
  logic done;
  logic [CW-1:0] gray_out;

  logic [LB-1:0] linear_level [256];
  gray_job_t pending_gray [$];
  int mismatches = 0;
  int cycles = 0;

  srgb_luma_grayscale u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .red_in   (red_in),
    .green_in (green_in),
    .blue_in  (blue_in),
    .done     (done),
    .gray_out (gray_out)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // True when level L satisfies (2L-1)/(2*LEVEL_MAX) <= x^2.4 with
  // x = (200c+2805)/53805, checked exactly as fifth and twelfth powers.
  function automatic bit level_fits(int unsigned code, longint unsigned level);
    logic [319:0] lhs;
    logic [319:0] rhs;
    logic [319:0] odd;
    logic [319:0] base;
    if (level == 0) begin
      return 1'b1;
    end
    odd = 320'(64'd2 * level - 64'd1);
    base = 320'(64'd200 * 64'(code) + 64'd2805);
    lhs = odd;
    rhs = base;
    for (int k = 1; k < 5; k++) lhs = lhs * odd;
    for (int k = 0; k < 12; k++) lhs = lhs * 320'd53805;
    for (int k = 1; k < 12; k++) rhs = rhs * base;
    for (int k = 0; k < 5; k++) rhs = rhs * 320'(64'd2 * LEVEL_MAX);
    return lhs <= rhs;
  endfunction

  // Rounded linear level of one sRGB code. The power segment starts from a
  // floating-point estimate and is then settled by exact comparison.
  function automatic longint unsigned linear_of_code(int unsigned code);
    real lin;
    longint unsigned level;
    if (code <= 10) begin
      return (LEVEL_MAX * 64'(code) * 64'd200 + 64'd329460) / 64'd658920;
    end
    lin = ((code / 255.0 + 0.055) / 1.055) ** 2.4;
    level = $rtoi(lin * LEVEL_MAX + 0.5);
    if (level > LEVEL_MAX) begin
      level = LEVEL_MAX;
    end
    while (level < LEVEL_MAX && level_fits(code, level + 1)) level++;
    while (level > 0 && !level_fits(code, level)) level--;
    return level;
  endfunction

  function automatic logic [CW-1:0] predict_gray(logic [CW-1:0] r, logic [CW-1:0] g,
                                                 logic [CW-1:0] b);
    logic [33:0] acc;
    logic [LB-1:0] luma;
    logic [LB-1:0] floor_luma;
    int code;
    acc = 34'(LUMA_R) * 34'(linear_level[r]) + 34'(LUMA_G) * 34'(linear_level[g])
        + 34'(LUMA_B) * 34'(linear_level[b]) + 34'd32768;
    luma = LB'(acc >> 16);
    // The encoder only sees the top index bits of the luminance.
    floor_luma = (luma >> DROP_BITS) << DROP_BITS;
    code = 255;
    while (code > 0 && linear_level[code] > floor_luma) code--;
    return CW'(code);
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTED) begin
      $display("%0t ns: %s", $realtime, what);
    end
    mismatches++;
  endtask

  // Short gaps dominate, with an occasional long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // Leaves start high, so the caller either sends again or idles in the same step.
  task automatic send_pixel(input logic [CW-1:0] r, input logic [CW-1:0] g,
                            input logic [CW-1:0] b);
    gray_job_t job;
    start <= 1'b1;
    red_in <= r;
    green_in <= g;
    blue_in <= b;
    do @(posedge clk); while (busy !== 1'b0);
    job.red = r;
    job.green = g;
    job.blue = b;
    job.gray = predict_gray(r, g, b);
    pending_gray.push_back(job);
  endtask

  // Data is set to random values while start is low; none of it may be taken.
  task automatic idle_for(input int n);
    start <= 1'b0;
    red_in <= CW'($urandom);
    green_in <= CW'($urandom);
    blue_in <= CW'($urandom);
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_for_results(input int bound);
    int waited;
    waited = 0;
    start <= 1'b0;
    while (pending_gray.size() != 0 && waited < bound) begin
      @(posedge clk);
      waited++;
    end
  endtask

  task automatic test_corner_pixels();
    logic [23:0] corner [21];
    corner = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
               24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h0A0A0A, 24'h0B0B0B,
               24'h0A0000, 24'h000B00, 24'h00000A, 24'h010101, 24'h010000,
               24'h808080, 24'h7F7F7F, 24'h55AA55, 24'hAA55AA, 24'hFEFEFE,
               24'h4080C0};
    foreach (corner[k]) begin
      send_pixel(corner[k][23:16], corner[k][15:8], corner[k][7:0]);
    end
    wait_for_results(200);
  endtask

  task automatic test_random_stream();
    int kind;
    int gap;
    logic [CW-1:0] r;
    logic [CW-1:0] g;
    logic [CW-1:0] b;
    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      kind = $urandom_range(99);
      r = CW'($urandom);
      g = CW'($urandom);
      b = CW'($urandom);
      if (kind < 20) begin
        g = r;
        b = r;
      end else if (kind < 35) begin
        // Dark pixels keep the channels near the linear segment of the decode.
        r = CW'($urandom_range(20));
        g = CW'($urandom_range(20));
        b = CW'($urandom_range(20));
      end else if (kind < 45) begin
        r = CW'($urandom_range(255, 235));
        g = CW'($urandom_range(255, 235));
        b = CW'($urandom_range(255, 235));
      end
      send_pixel(r, g, b);
      if (n == RANDOM_PIXELS / 2) begin
        wait_for_results(200);
        idle_for(3);
      end else begin
        gap = pick_gap();
        if (gap != 0) begin
          idle_for(gap);
        end
      end
    end
    wait_for_results(200);
  endtask

  task automatic test_burst();
    for (int n = 0; n < 64; n++) begin
      send_pixel(CW'($urandom), CW'($urandom), CW'($urandom));
    end
    wait_for_results(200);
  endtask

  always @(posedge clk) begin
    gray_job_t job;
    if (!rst && done !== 1'b0) begin
      if (done !== 1'b1) begin
        report_mismatch("done is unknown");
      end else if (pending_gray.size() == 0) begin
        report_mismatch($sformatf("unexpected gray transfer %0d", gray_out));
      end else begin
        job = pending_gray.pop_front();
        if (gray_out !== job.gray) begin
          report_mismatch($sformatf("pixel %02h %02h %02h: gray %0d, predicted %0d",
                                    job.red, job.green, job.blue, gray_out, job.gray));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    for (int c = 0; c < 256; c++) begin
      linear_level[c] = LB'(linear_of_code(c));
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_pixels();
    test_random_stream();
    test_burst();
    wait_for_results(200);
    repeat (20) @(posedge clk);
    if (pending_gray.size() != 0) begin
      report_mismatch($sformatf("%0d gray results never arrived", pending_gray.size()));
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/sl_pkg.sv
rtl/sl_luma.sv
rtl/sl_search_step.sv
rtl/srgb_luma_grayscale.sv
dv/srgb_luma_grayscale_test.sv
